### rtl/core/crt_pkg.sv
// Shared types and constants of the CRT congruence solver.
`timescale 1ns / 1ps
package crt_pkg;

    // Field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned IN_DW    = 64;
    localparam int unsigned OUT_DW   = 72;
    localparam int unsigned COEF_W   = 34;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NC  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd2;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_PROD,
        OP_SOLVE_INIT,
        OP_SET_NC,
        OP_GCD_INIT,
        OP_GCD_DIV,
        OP_GCD_STEP,
        OP_COF_DIV,
        OP_R0_DIV,
        OP_INV_INIT,
        OP_EU_DIV,
        OP_EU_MUL,
        OP_EU_STEP,
        OP_FIX1,
        OP_FIX2,
        OP_T1_DIV,
        OP_T1_MUL,
        OP_T2_DIV,
        OP_T2_MUL,
        OP_T3_DIV,
        OP_ACC,
        OP_OUT
    } t_op;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_PROD,
        S_SOLVE,
        S_CHK_FETCH,
        S_CHK_ZERO,
        S_GCD_TEST,
        S_GCD_DIV,
        S_GCD_STEP,
        S_POST,
        S_SUM_FETCH,
        S_COF_DIV,
        S_R0_DIV,
        S_INV_INIT,
        S_EU_TEST,
        S_EU_MUL,
        S_EU_STEP,
        S_FIX1,
        S_FIX2,
        S_T1_DIV,
        S_T1_MUL,
        S_T2_DIV,
        S_T2_MUL,
        S_T3_DIV,
        S_ACC,
        S_OUT,
        S_WAIT
    } t_state;

    // Datapath status back to the controller
    typedef struct packed {
        logic div_busy;
        logic out_busy;
        logic mod_i_zero;
        logic a_one;
        logic b_zero;
        logic ovf;
    } t_dp_status;

endpackage

### rtl/core/crt_divider.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module crt_divider
    import crt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0]   i_divisor,
    output logic                o_busy,
    output logic [2*WORD_W-1:0] o_quo,
    output logic [WORD_W-1:0]   o_rem
);

    localparam int unsigned CNT_W = $clog2(2*WORD_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [2*WORD_W-1:0] r_quo;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_dsr;
    logic [WORD_W:0]     w_shift;
    logic [WORD_W+1:0]   w_diff;

    // one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[2*WORD_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '1;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[WORD_W+1]) begin
                r_rem <= w_diff[WORD_W-1:0];
                r_quo <= {r_quo[2*WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WORD_W-1:0];
                r_quo <= {r_quo[2*WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### rtl/core/crt_datapath.sv
// Datapath: congruence stores, running product, Euclid registers, result word.
`timescale 1ns / 1ps
module crt_datapath
    import crt_pkg::*;
#(
    parameter int unsigned IW = 3
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [IW-1:0]     i_rd_i,
    input  logic [IW-1:0]     i_rd_j,
    input  logic [WORD_W-1:0] i_residue,
    input  logic [WORD_W-1:0] i_modulus,
    input  logic              i_m_tready,
    output t_dp_status        o_status,
    output logic              o_m_tvalid,
    output logic [OUT_DW-1:0] o_m_tdata
);

    localparam int unsigned DEPTH = 2**IW;

    // congruence stores
    logic [WORD_W-1:0] r_res_mem [DEPTH];
    logic [WORD_W-1:0] r_mod_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_ri, r_rd_mi, r_rd_mj;

    logic [WORD_W-1:0]        r_prod;
    logic                     r_ovf;
    logic                     r_nc;
    logic [2*WORD_W-1:0]      r_p64;
    logic [WORD_W-1:0]        r_a, r_b, r_t, r_cof, r_sum;
    logic signed [COEF_W-1:0] r_c0, r_c1, r_qc;
    logic                     r_valid;
    logic [WORD_W-1:0]        r_sol, r_cmod;
    logic [STAT_W-1:0]        r_stat;

    logic                     w_start;
    logic [2*WORD_W-1:0]      w_dvd;
    logic [WORD_W-1:0]        w_dsr;
    logic                     w_busy;
    logic [2*WORD_W-1:0]      w_quo;
    logic [WORD_W-1:0]        w_rem;
    logic signed [2*WORD_W+2:0] w_qc;
    logic signed [COEF_W-1:0] w_mi_s;
    logic [WORD_W:0]          w_acc;

    // stores: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (i_op == OP_STORE) begin
            r_res_mem[i_wr_addr] <= i_residue;
            r_mod_mem[i_wr_addr] <= i_modulus;
        end
        r_rd_ri <= r_res_mem[i_rd_i];
        r_rd_mi <= r_mod_mem[i_rd_i];
        r_rd_mj <= r_mod_mem[i_rd_j];
    end

    // divider operand select
    always_comb begin
        w_start = 1'b1;
        w_dvd   = {{WORD_W{1'b0}}, r_a};
        w_dsr   = r_rd_mi;
        case (i_op)
            OP_GCD_DIV: begin
                w_dvd = {{WORD_W{1'b0}}, r_a};
                w_dsr = r_b;
            end
            OP_EU_DIV: begin
                w_dvd = {{WORD_W{1'b0}}, r_a};
                w_dsr = r_b;
            end
            OP_COF_DIV: w_dvd = {{WORD_W{1'b0}}, r_prod};
            OP_R0_DIV:  w_dvd = {{WORD_W{1'b0}}, w_quo[WORD_W-1:0]};
            OP_T1_DIV:  w_dvd = {{WORD_W{1'b0}}, r_rd_ri};
            OP_T2_DIV:  w_dvd = r_p64;
            OP_T3_DIV: begin
                w_dvd = r_p64;
                w_dsr = r_prod;
            end
            default:    w_start = 1'b0;
        endcase
    end

    crt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_busy     (w_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    assign w_qc   = $signed({1'b0, w_quo[WORD_W-1:0]}) * r_c1;
    assign w_mi_s = $signed({{(COEF_W-WORD_W){1'b0}}, r_rd_mi});
    assign w_acc  = {1'b0, r_sum} + {1'b0, w_rem};

    // control state: running product and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= WORD_W'(1);
            r_ovf  <= 1'b0;
        end else if (i_op == OP_PROD) begin
            r_prod <= r_p64[WORD_W-1:0];
            r_ovf  <= r_ovf | (|r_p64[2*WORD_W-1:WORD_W]);
        end else if (i_op == OP_OUT) begin
            r_prod <= WORD_W'(1);
            r_ovf  <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_STORE:      r_p64 <= r_prod * i_modulus;
            OP_SOLVE_INIT: begin
                r_sum <= '0;
                r_nc  <= 1'b0;
            end
            OP_SET_NC:     r_nc <= 1'b1;
            OP_GCD_INIT: begin
                r_a <= r_rd_mi;
                r_b <= r_rd_mj;
            end
            OP_GCD_STEP: begin
                r_a <= r_b;
                r_b <= w_rem;
            end
            OP_R0_DIV:     r_cof <= w_quo[WORD_W-1:0];
            OP_INV_INIT: begin
                r_a  <= w_rem;
                r_b  <= r_rd_mi;
                r_c0 <= COEF_W'(1);
                r_c1 <= '0;
            end
            OP_EU_MUL: begin
                r_qc <= w_qc[COEF_W-1:0];
                r_t  <= w_rem;
            end
            OP_EU_STEP: begin
                r_a  <= r_b;
                r_b  <= r_t;
                r_c0 <= r_c1;
                r_c1 <= r_c0 - r_qc;
            end
            OP_FIX1: if (r_c0 < 0) r_c0 <= r_c0 + w_mi_s;
            OP_FIX2: if (r_c0 >= w_mi_s) r_c0 <= r_c0 - w_mi_s;
            OP_T1_MUL:     r_p64 <= w_rem * r_c0[WORD_W-1:0];
            OP_T2_MUL:     r_p64 <= w_rem * r_cof;
            OP_ACC: begin
                if (w_acc >= {1'b0, r_prod}) begin
                    r_sum <= WORD_W'(w_acc - {1'b0, r_prod});
                end else begin
                    r_sum <= w_acc[WORD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // result word, held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op == OP_OUT) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_OUT) begin
            r_cmod <= r_prod;
            r_sol  <= (r_nc || r_ovf) ? '0 : r_sum;
            r_stat <= r_nc ? ST_NC : (r_ovf ? ST_OVF : ST_OK);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(OUT_DW-2*WORD_W-STAT_W){1'b0}}, r_stat, r_cmod, r_sol};

    assign o_status.div_busy   = w_busy;
    assign o_status.out_busy   = r_valid & ~i_m_tready;
    assign o_status.mod_i_zero = (r_rd_mi == '0);
    assign o_status.a_one      = (r_a == WORD_W'(1));
    assign o_status.b_zero     = (r_b == '0);
    assign o_status.ovf        = r_ovf;

endmodule

### rtl/core/crt_ctrl.sv
// Controller: sequences storage, coprimality checks and the CRT sum.
`timescale 1ns / 1ps
module crt_ctrl
    import crt_pkg::*;
#(
    parameter int unsigned MAX_CONGRUENCES = 8,
    parameter int unsigned IW = 3,
    parameter int unsigned CW = 4
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    input  t_dp_status    i_status,
    output logic          o_s_tready,
    output t_op           o_op,
    output logic [IW-1:0] o_wr_addr,
    output logic [IW-1:0] o_rd_i,
    output logic [IW-1:0] o_rd_j
);

    t_state        r_state, n_state;
    t_state        r_ret, n_ret;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic          r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_last  <= n_last;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_i        = r_i;
        n_j        = r_j;
        n_n        = r_n;
        n_last     = r_last;
        o_op       = OP_NONE;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_last = i_s_tlast;
                    if (r_n < CW'(MAX_CONGRUENCES)) begin
                        o_op    = OP_STORE;
                        n_n     = r_n + CW'(1);
                        n_state = S_PROD;
                    end else if (i_s_tlast) begin
                        n_state = S_SOLVE;
                    end
                end
            end
            S_PROD: begin
                o_op    = OP_PROD;
                n_state = r_last ? S_SOLVE : S_IDLE;
            end
            S_SOLVE: begin
                o_op    = OP_SOLVE_INIT;
                n_i     = '0;
                n_j     = CW'(1);
                n_state = S_CHK_FETCH;
            end
            S_CHK_FETCH: n_state = S_CHK_ZERO;
            S_CHK_ZERO: begin
                if (i_status.mod_i_zero) begin
                    o_op    = OP_SET_NC;
                    n_state = S_OUT;
                end else if (r_j < r_n) begin
                    o_op    = OP_GCD_INIT;
                    n_state = S_GCD_TEST;
                end else if ((r_i + CW'(1)) < r_n) begin
                    n_i     = r_i + CW'(1);
                    n_j     = r_i + CW'(2);
                    n_state = S_CHK_FETCH;
                end else begin
                    n_state = S_POST;
                end
            end
            S_GCD_TEST: begin
                if (i_status.b_zero) begin
                    if (!i_status.a_one) begin
                        o_op    = OP_SET_NC;
                        n_state = S_OUT;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_CHK_FETCH;
                    end
                end else begin
                    n_state = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                o_op    = OP_GCD_DIV;
                n_ret   = S_GCD_STEP;
                n_state = S_WAIT;
            end
            S_GCD_STEP: begin
                o_op    = OP_GCD_STEP;
                n_state = S_GCD_TEST;
            end
            S_POST: begin
                if (i_status.ovf) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = '0;
                    n_state = S_SUM_FETCH;
                end
            end
            S_SUM_FETCH: n_state = S_COF_DIV;
            S_COF_DIV: begin
                o_op    = OP_COF_DIV;
                n_ret   = S_R0_DIV;
                n_state = S_WAIT;
            end
            S_R0_DIV: begin
                o_op    = OP_R0_DIV;
                n_ret   = S_INV_INIT;
                n_state = S_WAIT;
            end
            S_INV_INIT: begin
                o_op    = OP_INV_INIT;
                n_state = S_EU_TEST;
            end
            S_EU_TEST: begin
                if (i_status.b_zero) begin
                    n_state = S_FIX1;
                end else begin
                    o_op    = OP_EU_DIV;
                    n_ret   = S_EU_MUL;
                    n_state = S_WAIT;
                end
            end
            S_EU_MUL: begin
                o_op    = OP_EU_MUL;
                n_state = S_EU_STEP;
            end
            S_EU_STEP: begin
                o_op    = OP_EU_STEP;
                n_state = S_EU_TEST;
            end
            S_FIX1: begin
                o_op    = OP_FIX1;
                n_state = S_FIX2;
            end
            S_FIX2: begin
                o_op    = OP_FIX2;
                n_state = S_T1_DIV;
            end
            S_T1_DIV: begin
                o_op    = OP_T1_DIV;
                n_ret   = S_T1_MUL;
                n_state = S_WAIT;
            end
            S_T1_MUL: begin
                o_op    = OP_T1_MUL;
                n_state = S_T2_DIV;
            end
            S_T2_DIV: begin
                o_op    = OP_T2_DIV;
                n_ret   = S_T2_MUL;
                n_state = S_WAIT;
            end
            S_T2_MUL: begin
                o_op    = OP_T2_MUL;
                n_state = S_T3_DIV;
            end
            S_T3_DIV: begin
                o_op    = OP_T3_DIV;
                n_ret   = S_ACC;
                n_state = S_WAIT;
            end
            S_ACC: begin
                o_op = OP_ACC;
                n_i  = r_i + CW'(1);
                n_state = ((r_i + CW'(1)) < r_n) ? S_SUM_FETCH : S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_op    = OP_OUT;
                    n_n     = '0;
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_wr_addr = r_n[IW-1:0];
    assign o_rd_i    = r_i[IW-1:0];
    assign o_rd_j    = r_j[IW-1:0];

    // a wait always follows a divider start
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && $past(r_state) != S_WAIT) |-> i_status.div_busy)
        else $error("wait entered without a running division");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_CONGRUENCES))
        else $error("entry count beyond store depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT) |-> !i_status.out_busy)
        else $error("result word overwritten while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_STORE) |=> (r_state == S_PROD))
        else $error("stored entry not multiplied in");

endmodule

### rtl/core/crt_congruence_solver_core.sv
// Top level of the CRT congruence solver.
// Usage: congruences arrive on the slave channel, one word each, residue in
// tdata[31:0], modulus in tdata[63:32], tlast on the final congruence of a
// system. Up to MAX_CONGRUENCES entries are kept; further words are taken
// and dropped, though a tlast among them still closes the system.
// A plain word is stored, then multiplied into the running product. On tlast
// the solver checks each modulus pair with a gcd on the shared divider (each
// division is started, then waited out in a wait state), then for each entry
// runs a cofactor division, extended Euclid (one division per step) and four
// modular reductions, all on that divider.
// One result word appears on the master channel per system: solution,
// combined modulus and status. It sits in an output register, so the next
// system is taken in while the result waits; the solver only holds in its
// final step if an earlier result is still untaken.
// Reset (synchronous, active low) clears the entry count, the running
// product to one and the output valid.
`timescale 1ns / 1ps
module crt_congruence_solver_core
    import crt_pkg::*;
#(
    parameter int unsigned MAX_CONGRUENCES = 8
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // residue[31:0], modulus[63:32]
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata    // solution[31:0], combined_modulus[63:32],
                                           // status[65:64], zero fill
);

    localparam int unsigned IW = (MAX_CONGRUENCES > 1) ? $clog2(MAX_CONGRUENCES) : 1;
    localparam int unsigned CW = $clog2(MAX_CONGRUENCES + 1) + 1;

    t_op           w_op;
    t_dp_status    w_status;
    logic [IW-1:0] w_wr_addr, w_rd_i, w_rd_j;

    crt_ctrl #(
        .MAX_CONGRUENCES (MAX_CONGRUENCES),
        .IW              (IW),
        .CW              (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_op       (w_op),
        .o_wr_addr  (w_wr_addr),
        .o_rd_i     (w_rd_i),
        .o_rd_j     (w_rd_j)
    );

    crt_datapath #(
        .IW (IW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_wr_addr  (w_wr_addr),
        .i_rd_i     (w_rd_i),
        .i_rd_j     (w_rd_j),
        .i_residue  (i_s_tdata[WORD_W-1:0]),
        .i_modulus  (i_s_tdata[2*WORD_W-1:WORD_W]),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
